[rtl/rlydf_pkg.sv]
// ----------------------------------------------------------------------------
// rlydf_pkg
// Shared types and constants for the relay packet deframer.
// ----------------------------------------------------------------------------
package rlydf_pkg;

  // header layout
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned LastIdx     = HeaderBytes - 1;

  // register widths and reset values
  localparam int unsigned VersionW       = 16;
  localparam int unsigned LengthW        = 32;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned CfgIndexW      = 1;
  localparam logic [VersionW-1:0] VersionReset = 16'd1;
  localparam logic [LengthW-1:0]  BulkReset    = 32'd4194304;

  // fixed length limits
  localparam logic [LengthW-1:0] LimitType5   = 32'd533;
  localparam logic [LengthW-1:0] LimitDefault = 32'd64;

  // packet types with special limits
  localparam logic [7:0] TypeBulk  = 8'd2;
  localparam logic [7:0] TypeFive  = 8'd5;
  localparam logic [7:0] TypeFirst = 8'd1;
  localparam logic [7:0] TypeLast  = 8'd7;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegExpectedVersion = 1'd0;
  localparam logic [CfgIndexW-1:0] RegBulkLengthLimit = 1'd1;

  // stream packing
  localparam int unsigned TdataW = 48;
  localparam int unsigned TuserW = 2;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC    = 3'd0,
    ERR_VERSION  = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_TYPE     = 3'd3,
    ERR_LENGTH   = 3'd4
  } err_t;

  // one result item
  typedef struct packed {
    kind_t               kind;
    logic [2:0]          pkind;
    logic [LengthW-1:0]  length;
    logic [7:0]          data;
    logic                fin;
    err_t                err;
  } res_t;

  // magic byte expected at header positions zero to three
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'h4B;
      2'd1:    m = 8'h56;
      2'd2:    m = 8'h4D;
      default: m = 8'h58;
    endcase
    return m;
  endfunction

endpackage

[rtl/rlydf_parse.sv]
// ----------------------------------------------------------------------------
// rlydf_parse
// Header collection, header checks and payload counting; one byte per step.
// ----------------------------------------------------------------------------
module rlydf_parse (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [7:0]                        rx_byte,
  input  logic [rlydf_pkg::VersionW-1:0]    expected_version,
  input  logic [rlydf_pkg::LengthW-1:0]     bulk_length_limit,
  output logic                              res_valid,
  output rlydf_pkg::res_t                   res
);

  logic [rlydf_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic                           magic_ok_r, magic_ok_nxt;
  logic [rlydf_pkg::VersionW-1:0] version_r, version_nxt;
  logic [7:0]                     type_r, type_nxt;
  logic [7:0]                     rsvd_r, rsvd_nxt;
  logic [rlydf_pkg::LengthW-1:0]  length_r, length_nxt;
  logic [rlydf_pkg::LengthW-1:0]  left_r, left_nxt;
  logic                           in_payload_r, in_payload_nxt;

  logic [rlydf_pkg::LengthW-1:0]  length_full;
  logic [rlydf_pkg::LengthW-1:0]  limit;
  logic                           bad;
  rlydf_pkg::err_t                err;

  // final length as seen with the last header byte
  assign length_full = {length_r[rlydf_pkg::LengthW-9:0], rx_byte};

  // length limit by type
  always_comb begin
    if (type_r == rlydf_pkg::TypeBulk) begin
      limit = bulk_length_limit;
    end else if (type_r == rlydf_pkg::TypeFive) begin
      limit = rlydf_pkg::LimitType5;
    end else begin
      limit = rlydf_pkg::LimitDefault;
    end
  end

  // header checks in priority order
  always_comb begin
    bad = 1'b1;
    err = rlydf_pkg::ERR_MAGIC;
    if (!magic_ok_r) begin
      err = rlydf_pkg::ERR_MAGIC;
    end else if (version_r != expected_version) begin
      err = rlydf_pkg::ERR_VERSION;
    end else if (rsvd_r != 8'd0) begin
      err = rlydf_pkg::ERR_RESERVED;
    end else if (type_r < rlydf_pkg::TypeFirst || type_r > rlydf_pkg::TypeLast) begin
      err = rlydf_pkg::ERR_TYPE;
    end else if (length_full > limit) begin
      err = rlydf_pkg::ERR_LENGTH;
    end else begin
      bad = 1'b0;
    end
  end

  // next state and result
  always_comb begin
    idx_nxt        = idx_r;
    magic_ok_nxt   = magic_ok_r;
    version_nxt    = version_r;
    type_nxt       = type_r;
    rsvd_nxt       = rsvd_r;
    length_nxt     = length_r;
    left_nxt       = left_r;
    in_payload_nxt = in_payload_r;
    res_valid      = 1'b0;
    res            = '0;

    if (in_payload_r) begin
      left_nxt   = left_r - 1'b1;
      res_valid  = 1'b1;
      res.kind   = rlydf_pkg::KIND_PAYLOAD;
      res.pkind  = type_r[2:0];
      res.length = length_r;
      res.data   = rx_byte;
      res.fin    = (left_nxt == '0);
      if (left_nxt == '0) begin
        in_payload_nxt = 1'b0;
        idx_nxt        = '0;
        magic_ok_nxt   = 1'b1;
      end
    end else begin
      // capture header fields
      if (idx_r < 4'd4) begin
        if (rx_byte != rlydf_pkg::magic_byte(idx_r[1:0])) begin
          magic_ok_nxt = 1'b0;
        end
      end else if (idx_r == 4'd4) begin
        version_nxt = {rx_byte, 8'd0};
      end else if (idx_r == 4'd5) begin
        version_nxt = {version_r[15:8], rx_byte};
      end else if (idx_r == 4'd6) begin
        type_nxt = rx_byte;
      end else if (idx_r == 4'd7) begin
        rsvd_nxt = rx_byte;
      end else begin
        length_nxt = length_full;
      end

      if (idx_r != rlydf_pkg::IdxW'(rlydf_pkg::LastIdx)) begin
        idx_nxt = idx_r + 1'b1;
      end else begin
        res_valid    = 1'b1;
        idx_nxt      = '0;
        magic_ok_nxt = 1'b1;
        if (bad) begin
          res.kind = rlydf_pkg::KIND_REJECT;
          res.fin  = 1'b1;
          res.err  = err;
        end else begin
          res.kind   = rlydf_pkg::KIND_HEADER;
          res.pkind  = type_r[2:0];
          res.length = length_full;
          res.fin    = (length_full == '0);
          if (length_full != '0) begin
            left_nxt       = length_full;
            in_payload_nxt = 1'b1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      magic_ok_r   <= 1'b1;
      version_r    <= '0;
      type_r       <= '0;
      rsvd_r       <= '0;
      length_r     <= '0;
      left_r       <= '0;
      in_payload_r <= 1'b0;
    end else if (step) begin
      idx_r        <= idx_nxt;
      magic_ok_r   <= magic_ok_nxt;
      version_r    <= version_nxt;
      type_r       <= type_nxt;
      rsvd_r       <= rsvd_nxt;
      length_r     <= length_nxt;
      left_r       <= left_nxt;
      in_payload_r <= in_payload_nxt;
    end
  end

endmodule

[rtl/relay_packet_deframer.sv]
// ----------------------------------------------------------------------------
// relay_packet_deframer
// Length-prefixed packet deframer: 12-byte header check, payload forwarding.
// ----------------------------------------------------------------------------
// Usage:
// - in_* carries one received byte per transaction in in_tdata[7:0].
// - out_* carries one result per transaction: header accepted, payload byte
//   or header rejected (kind in out_tuser), out_tlast on the last payload
//   byte, on a zero-length header and on a reject.
// - header bytes one to eleven give no result; the twelfth gives the header
//   or reject result, then each payload byte gives one result.
// - cfg_we/cfg_index/cfg_data write expected_version (index 0) and
//   bulk_length_limit (index 1); write only while the block is idle.
// Timing:
// - one byte per cycle sustained while the receiver does not stall; a result
//   passes from the input register through the parse logic into the output
//   register before it is on out_*.
// - when the receiver stalls, the output register holds its result and the
//   input register keeps taking bytes that give no result; in_tready drops
//   once a byte that gives a result is waiting.
// Reset (rst_n low, synchronous) empties both registers, restarts the header
// hunt and loads the register reset values.
// ----------------------------------------------------------------------------
module relay_packet_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  // slave side
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  // master side
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] packet_kind, [34:3] payload_length, [42:35] payload_byte,
  // [45:43] error_code, [47:46] zero
  output logic [rlydf_pkg::TdataW-1:0]        out_tdata,
  output logic [rlydf_pkg::TuserW-1:0]        out_tuser,  // [1:0] result_kind
  output logic                                out_tlast,  // final_flag
  // configuration
  input  logic                                cfg_we,
  input  logic [rlydf_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [rlydf_pkg::CfgDataW-1:0]      cfg_data
);

  logic                               s1_valid_r;
  logic [7:0]                         s1_byte_r;
  logic                               out_valid_r;
  rlydf_pkg::res_t                    out_res_r;
  logic [rlydf_pkg::VersionW-1:0]     version_cfg_r;
  logic [rlydf_pkg::LengthW-1:0]      bulk_cfg_r;

  logic                               res_valid;
  rlydf_pkg::res_t                    res;
  logic                               out_free;
  logic                               adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_cfg_r <= rlydf_pkg::VersionReset;
      bulk_cfg_r    <= rlydf_pkg::BulkReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlydf_pkg::RegExpectedVersion: version_cfg_r <= cfg_data[rlydf_pkg::VersionW-1:0];
        rlydf_pkg::RegBulkLengthLimit: bulk_cfg_r    <= cfg_data[rlydf_pkg::LengthW-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!res_valid || out_free);
  assign in_tready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // parser
  rlydf_parse u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (adv),
    .rx_byte           (s1_byte_r),
    .expected_version  (version_cfg_r),
    .bulk_length_limit (bulk_cfg_r),
    .res_valid         (res_valid),
    .res               (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  // stream packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.err, out_res_r.data, out_res_r.length,
                       out_res_r.pkind};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.fin;

endmodule
